// ===== rtl/wheel_speed_light_controller_top_macros.svh =====
// ----------------------------------------------------------------------------
// Wheel speed light controller assertion macros
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef WHEEL_SPEED_LIGHT_CONTROLLER_TOP_MACROS_SVH
`define WHEEL_SPEED_LIGHT_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication.
`define WSLC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define WSLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wslc_pkg.sv =====
// ----------------------------------------------------------------------------
// Wheel speed light controller package
// Shared types, register codes and reset values of the controller.
// ----------------------------------------------------------------------------
package wslc_pkg;

   // Field and counter widths.
   localparam int RateWidth   = 8;
   localparam int IndexWidth  = 5;
   localparam int SetWidth    = 2;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDataWidth = 12;

   // Register reset values.
   localparam logic [9:0]  WINDOW_LENGTH_RESET    = 10'd300;
   localparam logic [11:0] HOLD_TICKS_RESET       = 12'd1000;
   localparam logic [7:0]  ON_THRESHOLD_RESET     = 8'd3;
   localparam logic [7:0]  RESUME_THRESHOLD_RESET = 8'd5;
   localparam logic [7:0]  FAST_THRESHOLD_RESET   = 8'd60;
   localparam logic [7:0]  MEDIUM_THRESHOLD_RESET = 8'd30;
   localparam logic [7:0]  DELAY_BASE_RESET       = 8'd25;

   // Configuration register indexes.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_WINDOW_LENGTH    = 3'd0,
      CSR_HOLD_TICKS       = 3'd1,
      CSR_ON_THRESHOLD     = 3'd2,
      CSR_RESUME_THRESHOLD = 3'd3,
      CSR_FAST_THRESHOLD   = 3'd4,
      CSR_MEDIUM_THRESHOLD = 3'd5,
      CSR_DELAY_BASE       = 3'd6
   } csr_index_type;

   // Pattern table selection.
   typedef enum logic [SetWidth-1:0] {
      SET_SLOW   = 2'd0,
      SET_MEDIUM = 2'd1,
      SET_FAST   = 2'd2,
      SET_IDLE   = 2'd3
   } pattern_set_type;

   // Power state machine.
   typedef enum logic [1:0] {
      PWR_OFF  = 2'd0,
      PWR_ON   = 2'd1,
      PWR_HOLD = 2'd2
   } power_state_type;

   // Sensor edge detector.
   typedef enum logic [1:0] {
      EDGE_IDLE     = 2'd0,
      EDGE_RISE     = 2'd1,
      EDGE_WAITFALL = 2'd2
   } edge_state_type;

   // Display sequencer.
   typedef enum logic {
      DSP_WAIT   = 1'b0,
      DSP_SCROLL = 1'b1
   } display_state_type;

   // Power machine status after the current tick.
   typedef struct packed {
      logic on;
      logic idle;
   } power_status_type;

   // Rate window status after the current tick.
   typedef struct packed {
      logic                 strobe;
      logic [RateWidth-1:0] rate;
   } rate_status_type;

   // Display sequencer result for the current tick.
   typedef struct packed {
      logic                  scroll;
      logic [SetWidth-1:0]   pset;
      logic [IndexWidth-1:0] pidx;
   } display_status_type;

endpackage

// ===== rtl/wslc_power.sv =====
// ----------------------------------------------------------------------------
// Wheel speed light controller power machine
// Off, on and hold-off states driven by the latched pulse rate.
// ----------------------------------------------------------------------------
module wslc_power (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic [wslc_pkg::RateWidth-1:0]   rate,
   input  logic [7:0]                       on_threshold,
   input  logic [7:0]                       resume_threshold,
   input  logic [11:0]                      hold_ticks,
   output wslc_pkg::power_status_type       status
);

   localparam logic [12:0] HoldMax = 13'h1FFF;

   wslc_pkg::power_state_type state_ff, state_in;
   logic [12:0] hold_count_ff, hold_count_in;
   logic        hold_clear;
   logic [12:0] hold_base;
   logic [12:0] hold_limit;

   assign hold_limit = {1'b0, hold_ticks};

   // Next state.
   always_comb begin
      state_in   = state_ff;
      hold_clear = 1'b0;
      case (state_ff)
         wslc_pkg::PWR_OFF: begin
            if (rate >= on_threshold) state_in = wslc_pkg::PWR_ON;
         end
         wslc_pkg::PWR_ON: begin
            if (rate < on_threshold) state_in = wslc_pkg::PWR_HOLD;
         end
         wslc_pkg::PWR_HOLD: begin
            if (hold_count_ff < hold_limit && rate > resume_threshold) begin
               state_in   = wslc_pkg::PWR_ON;
               hold_clear = 1'b1;
            end else if (hold_count_ff > hold_limit) begin
               state_in   = wslc_pkg::PWR_OFF;
               hold_clear = 1'b1;
            end
         end
         default: begin
            state_in = wslc_pkg::PWR_OFF;
         end
      endcase
   end

   // Hold counter counts every tick spent in hold-off, saturating.
   always_comb begin
      hold_base     = hold_clear ? 13'd0 : hold_count_ff;
      hold_count_in = hold_base;
      if (state_in == wslc_pkg::PWR_HOLD && hold_base != HoldMax) begin
         hold_count_in = hold_base + 13'd1;
      end
   end

   // Status outputs.
   always_comb begin
      status.on   = (state_in != wslc_pkg::PWR_OFF);
      status.idle = (state_in == wslc_pkg::PWR_HOLD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wslc_pkg::PWR_OFF;
         hold_count_ff <= 13'd0;
      end else if (step) begin
         state_ff      <= state_in;
         hold_count_ff <= hold_count_in;
      end
   end

endmodule

// ===== rtl/wslc_rate.sv =====
// ----------------------------------------------------------------------------
// Wheel speed light controller rate window
// Counts sensor rising edges and latches the tally once per window.
// ----------------------------------------------------------------------------
module wslc_rate (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             sensor_active,
   input  logic [9:0]                       window_length,
   output logic [wslc_pkg::RateWidth-1:0]   rate_now,
   output wslc_pkg::rate_status_type        status
);

   wslc_pkg::edge_state_type edge_ff, edge_in;
   logic [7:0]  tally_ff, tally_in;
   logic [7:0]  tally_inc;
   logic [10:0] elapsed_ff, elapsed_in;
   logic [7:0]  latched_ff, latched_in;
   logic        strobe;

   // Edge detector next state.
   always_comb begin
      edge_in = edge_ff;
      case (edge_ff)
         wslc_pkg::EDGE_IDLE:     if (sensor_active) edge_in = wslc_pkg::EDGE_RISE;
         wslc_pkg::EDGE_RISE:     edge_in = wslc_pkg::EDGE_WAITFALL;
         wslc_pkg::EDGE_WAITFALL: if (!sensor_active) edge_in = wslc_pkg::EDGE_IDLE;
         default:                 edge_in = wslc_pkg::EDGE_IDLE;
      endcase
   end

   // Tally and window counter.
   always_comb begin
      tally_inc = tally_ff;
      if (edge_in == wslc_pkg::EDGE_RISE && tally_ff != 8'hFF) begin
         tally_inc = tally_ff + 8'd1;
      end
      strobe = (elapsed_ff > {1'b0, window_length});
      if (strobe) begin
         latched_in = tally_inc;
         tally_in   = 8'd0;
         elapsed_in = 11'd0;
      end else begin
         latched_in = latched_ff;
         tally_in   = tally_inc;
         elapsed_in = elapsed_ff + 11'd1;
      end
   end

   assign rate_now      = latched_ff;
   assign status.strobe = strobe;
   assign status.rate   = latched_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff    <= wslc_pkg::EDGE_IDLE;
         tally_ff   <= 8'd0;
         elapsed_ff <= 11'd0;
         latched_ff <= 8'd0;
      end else if (step) begin
         edge_ff    <= edge_in;
         tally_ff   <= tally_in;
         elapsed_ff <= elapsed_in;
         latched_ff <= latched_in;
      end
   end

endmodule

// ===== rtl/wslc_display.sv =====
// ----------------------------------------------------------------------------
// Wheel speed light controller display sequencer
// Paces scroll beats by a speed dependent delay and picks table and entry.
// ----------------------------------------------------------------------------
module wslc_display #(
   parameter int RIDE_PATTERN_LAST = 22,
   parameter int IDLE_PATTERN_LAST = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  wslc_pkg::power_status_type       power,
   input  logic [wslc_pkg::RateWidth-1:0]   rate,
   input  logic [7:0]                       delay_base,
   input  logic [7:0]                       fast_threshold,
   input  logic [7:0]                       medium_threshold,
   output wslc_pkg::display_status_type     status
);

   localparam logic [8:0] WaitMax = 9'h1FF;
   localparam logic [wslc_pkg::IndexWidth-1:0] RideLast =
      wslc_pkg::IndexWidth'(RIDE_PATTERN_LAST);
   localparam logic [wslc_pkg::IndexWidth-1:0] IdleLast =
      wslc_pkg::IndexWidth'(IDLE_PATTERN_LAST);

   wslc_pkg::display_state_type state_ff, state_in;
   logic [8:0]                      wait_ff, wait_in;
   logic [wslc_pkg::IndexWidth-1:0] index_ff, index_in;
   logic [7:0]                      delay;
   logic [wslc_pkg::SetWidth-1:0]   speed_set;
   logic                            scroll;

   // Delay floors at zero; table by speed.
   always_comb begin
      delay = (delay_base > rate) ? (delay_base - rate) : 8'd0;
      if (rate > fast_threshold) begin
         speed_set = wslc_pkg::SET_FAST;
      end else if (rate > medium_threshold) begin
         speed_set = wslc_pkg::SET_MEDIUM;
      end else begin
         speed_set = wslc_pkg::SET_SLOW;
      end
   end

   // Next state; frozen while the system is off.
   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      index_in = index_ff;
      scroll   = 1'b0;
      if (power.on) begin
         case (state_ff)
            wslc_pkg::DSP_WAIT: begin
               if (wait_ff >= {1'b0, delay}) begin
                  scroll   = 1'b1;
                  state_in = wslc_pkg::DSP_SCROLL;
                  wait_in  = 9'd0;
                  if (power.idle) begin
                     index_in = (index_ff < IdleLast) ? index_ff + 1'b1 : '0;
                  end else begin
                     index_in = (index_ff < RideLast) ? index_ff + 1'b1 : '0;
                  end
               end else if (wait_ff != WaitMax) begin
                  wait_in = wait_ff + 9'd1;
               end
            end
            default: begin
               state_in = wslc_pkg::DSP_WAIT;
               if (wait_ff != WaitMax) wait_in = wait_ff + 9'd1;
            end
         endcase
      end
   end

   // Result fields; zero when no scroll happens.
   always_comb begin
      status.scroll = scroll;
      status.pset   = '0;
      status.pidx   = '0;
      if (scroll) begin
         status.pset = power.idle ? wslc_pkg::SET_IDLE : speed_set;
         status.pidx = index_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wslc_pkg::DSP_WAIT;
         wait_ff  <= 9'd0;
         index_ff <= '0;
      end else if (step) begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
         index_ff <= index_in;
      end
   end

endmodule

// ===== rtl/wheel_speed_light_controller_top.sv =====
// Path: a tick moves from the input register to the result register, shown on rsp.
// Throughput: one tick per clock; both the input register and the result register
// advance together, so only rsp_tready low stalls the input side.
// Reset: synchronous, active high; clears all sequencer state, empties both
// registers and loads the configuration registers with their default values.
`include "wheel_speed_light_controller_top_macros.svh"
// ----------------------------------------------------------------------------
// Wheel speed light controller top level
// Input register, power, rate and display logic, and the result register.
// ----------------------------------------------------------------------------
module wheel_speed_light_controller_top #(
   parameter int RIDE_PATTERN_LAST = 22,
   parameter int IDLE_PATTERN_LAST = 3
) (
   input  logic                                clock,
   input  logic                                reset,
   // Tick input: [0] sensor_active, [7:1] zero.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,
   // Result: [0] system_on, [1] holding_off, [2] window_strobe, [10:3] rate_count,
   // [11] scroll_strobe, [13:12] pattern_set, [18:14] pattern_index,
   // [19] clear_strip, [23:20] zero.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [23:0]                         rsp_tdata,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [wslc_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [wslc_pkg::CsrDataWidth-1:0]   csr_wdata
);

   // Configuration registers.
   logic [9:0]  window_length_ff;
   logic [11:0] hold_ticks_ff;
   logic [7:0]  on_threshold_ff;
   logic [7:0]  resume_threshold_ff;
   logic [7:0]  fast_threshold_ff;
   logic [7:0]  medium_threshold_ff;
   logic [7:0]  delay_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff    <= wslc_pkg::WINDOW_LENGTH_RESET;
         hold_ticks_ff       <= wslc_pkg::HOLD_TICKS_RESET;
         on_threshold_ff     <= wslc_pkg::ON_THRESHOLD_RESET;
         resume_threshold_ff <= wslc_pkg::RESUME_THRESHOLD_RESET;
         fast_threshold_ff   <= wslc_pkg::FAST_THRESHOLD_RESET;
         medium_threshold_ff <= wslc_pkg::MEDIUM_THRESHOLD_RESET;
         delay_base_ff       <= wslc_pkg::DELAY_BASE_RESET;
      end else if (csr_we) begin
         case (wslc_pkg::csr_index_type'(csr_index))
            wslc_pkg::CSR_WINDOW_LENGTH:    window_length_ff    <= csr_wdata[9:0];
            wslc_pkg::CSR_HOLD_TICKS:       hold_ticks_ff       <= csr_wdata;
            wslc_pkg::CSR_ON_THRESHOLD:     on_threshold_ff     <= csr_wdata[7:0];
            wslc_pkg::CSR_RESUME_THRESHOLD: resume_threshold_ff <= csr_wdata[7:0];
            wslc_pkg::CSR_FAST_THRESHOLD:   fast_threshold_ff   <= csr_wdata[7:0];
            wslc_pkg::CSR_MEDIUM_THRESHOLD: medium_threshold_ff <= csr_wdata[7:0];
            wslc_pkg::CSR_DELAY_BASE:       delay_base_ff       <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Input register and handshake.
   logic in_valid_ff;
   logic sensor_ff;
   logic rsp_valid_ff;
   logic step;

   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sensor_ff <= req_tdata[0];
      end
   end

   // Tick logic.
   wslc_pkg::power_status_type   power;
   wslc_pkg::rate_status_type    rate;
   wslc_pkg::display_status_type display;
   logic [wslc_pkg::RateWidth-1:0] rate_now;

   wslc_power u_power (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .rate             (rate_now),
      .on_threshold     (on_threshold_ff),
      .resume_threshold (resume_threshold_ff),
      .hold_ticks       (hold_ticks_ff),
      .status           (power)
   );

   wslc_rate u_rate (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .sensor_active (sensor_ff),
      .window_length (window_length_ff),
      .rate_now      (rate_now),
      .status        (rate)
   );

   wslc_display #(
      .RIDE_PATTERN_LAST (RIDE_PATTERN_LAST),
      .IDLE_PATTERN_LAST (IDLE_PATTERN_LAST)
   ) u_display (
      .clock            (clock),
      .reset            (reset),
      .step             (step),
      .power            (power),
      .rate             (rate.rate),
      .delay_base       (delay_base_ff),
      .fast_threshold   (fast_threshold_ff),
      .medium_threshold (medium_threshold_ff),
      .status           (display)
   );

   // Result register.
   logic [23:0] rsp_data_ff;
   logic [23:0] rsp_data_in;

   assign rsp_data_in = {4'd0, !power.on, display.pidx, display.pset, display.scroll,
                         rate.rate, rate.strobe, power.idle, power.on};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks.
   `WSLC_ASSERT_NOW(a_hold_implies_on, rsp_valid_ff && rsp_data_ff[1], rsp_data_ff[0] && !rsp_data_ff[19], "holding off while the system is off")
   `WSLC_ASSERT_NOW(a_no_scroll_zero, rsp_valid_ff && !rsp_data_ff[11], rsp_data_ff[18:12] == 7'd0, "pattern fields set without a scroll beat")
   `WSLC_ASSERT_NOW(a_idle_set, rsp_valid_ff && rsp_data_ff[11] && rsp_data_ff[1], rsp_data_ff[13:12] == wslc_pkg::SET_IDLE, "hold-off scroll not using the idle table")
   `WSLC_ASSERT_NEXT(a_in_held, in_valid_ff && !step, in_valid_ff && $stable(sensor_ff), "stalled tick lost from the input register")

endmodule

// ===== dv/wheel_speed_light_controller_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Wheel speed light controller testbench
// Sends sensor ticks into the controller and checks every status beat against
// a cycle-free model of the power machine, pulse counter, rate window and
// display sequencer kept in this bench. A short table of directed ticks and
// register writes comes first. It is followed by phases of random settings
// with pulse trains, quiet stretches, stuck levels and noise on the sensor.
// ----------------------------------------------------------------------------
module wheel_speed_light_controller_top_tb;

   localparam int RIDE_LAST     = 22;
   localparam int IDLE_LAST     = 3;
   localparam int RANDOM_TICKS  = 500;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 200000;
   localparam logic [wslc_pkg::CsrIdxWidth-1:0] CSR_SPARE_INDEX = 3'd7;

   // One status beat, laid out as in rsp_tdata[19:0].
   typedef struct packed {
      logic                            clear;
      logic [wslc_pkg::IndexWidth-1:0] pidx;
      logic [wslc_pkg::SetWidth-1:0]   pset;
      logic                            scroll;
      logic [wslc_pkg::RateWidth-1:0]  rate;
      logic                            strobe;
      logic                            idle;
      logic                            on;
   } tick_status_type;

   // One row of the directed table: a register write or a sensor tick.
   typedef struct {
      bit                                 is_write;
      logic [wslc_pkg::CsrIdxWidth-1:0]   reg_idx;
      logic [wslc_pkg::CsrDataWidth-1:0]  reg_value;
      logic                               level;
      bit                                 typed;
      tick_status_type                    want;
   } stim_row_type;

   // Status right after reset: lights off, strip blanked, nothing latched.
   localparam tick_status_type DARK_AT_RESET = '{clear: 1'b1, pidx: '0,
                                                 pset: wslc_pkg::SET_SLOW,
                                                 scroll: 1'b0, rate: '0, strobe: 1'b0,
                                                 idle: 1'b0, on: 1'b0};

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [23:0]                       rsp_tdata;
   logic                              csr_we = 1'b0;
   logic [wslc_pkg::CsrIdxWidth-1:0]  csr_index = '0;
   logic [wslc_pkg::CsrDataWidth-1:0] csr_wdata = '0;

   // Register copies and controller state of the model.
   logic [9:0]                    cfg_window;
   logic [11:0]                   cfg_hold;
   logic [7:0]                    cfg_on, cfg_resume, cfg_fast, cfg_medium, cfg_delay;
   wslc_pkg::edge_state_type      edge_state;
   wslc_pkg::power_state_type     power_state;
   wslc_pkg::display_state_type   disp_state;
   logic [7:0]                    pulse_tally, rate_latched;
   logic [10:0]                   window_ticks;
   logic [12:0]                   hold_ticks_run;
   logic [8:0]                    wait_ticks;
   logic [4:0]                    entry_idx;

   tick_status_type pending_status[$];
   stim_row_type    directed_rows[$];
   bit              steady_flow = 1'b0;
   int              mismatches = 0;
   int              cycle_count = 0;
   int              ticks_sent = 0;
   int              latch_beats = 0, scroll_beats = 0, hold_beats = 0, dark_beats = 0;

   wheel_speed_light_controller_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 12 ns clock.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Result side back-pressure, switched off in steady phases.
   always @(negedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= 16);
   end

   // Advances the model by one tick and returns the status it should report.
   function automatic tick_status_type advance_controller(input logic level);
      tick_status_type st;
      logic [7:0]      delay;
      st = '0;

      // Power machine first, so the display sees the new power state.
      case (power_state)
         wslc_pkg::PWR_OFF: if (rate_latched >= cfg_on) power_state = wslc_pkg::PWR_ON;
         wslc_pkg::PWR_ON:  if (rate_latched < cfg_on) power_state = wslc_pkg::PWR_HOLD;
         wslc_pkg::PWR_HOLD: begin
            if (hold_ticks_run < cfg_hold && rate_latched > cfg_resume) begin
               power_state = wslc_pkg::PWR_ON;
               hold_ticks_run = '0;
            end else if (hold_ticks_run > cfg_hold) begin
               power_state = wslc_pkg::PWR_OFF;
               hold_ticks_run = '0;
            end
         end
         default: power_state = wslc_pkg::PWR_OFF;
      endcase
      st.idle = (power_state == wslc_pkg::PWR_HOLD);
      if (st.idle && hold_ticks_run != '1) hold_ticks_run++;
      st.on    = (power_state != wslc_pkg::PWR_OFF);
      st.clear = !st.on;

      // Rising edges of the sensor level, one count per pulse.
      case (edge_state)
         wslc_pkg::EDGE_IDLE:     if (level) edge_state = wslc_pkg::EDGE_RISE;
         wslc_pkg::EDGE_RISE:     edge_state = wslc_pkg::EDGE_WAITFALL;
         wslc_pkg::EDGE_WAITFALL: if (!level) edge_state = wslc_pkg::EDGE_IDLE;
         default:                 edge_state = wslc_pkg::EDGE_IDLE;
      endcase
      if (edge_state == wslc_pkg::EDGE_RISE && pulse_tally != 8'hFF) pulse_tally++;

      // Rate window latch.
      if (window_ticks > cfg_window) begin
         rate_latched = pulse_tally;
         pulse_tally  = '0;
         window_ticks = '0;
         st.strobe    = 1'b1;
      end else begin
         window_ticks++;
      end
      st.rate = rate_latched;
      delay = (cfg_delay > rate_latched) ? cfg_delay - rate_latched : 8'd0;

      // Display sequencer runs only while powered.
      if (st.on) begin
         if (disp_state == wslc_pkg::DSP_WAIT) begin
            if (wait_ticks >= delay) begin
               if (!st.idle) begin
                  if (rate_latched > cfg_fast) st.pset = wslc_pkg::SET_FAST;
                  else if (rate_latched > cfg_medium) st.pset = wslc_pkg::SET_MEDIUM;
                  else st.pset = wslc_pkg::SET_SLOW;
                  entry_idx = (entry_idx < RIDE_LAST) ? entry_idx + 5'd1 : 5'd0;
               end else begin
                  st.pset = wslc_pkg::SET_IDLE;
                  entry_idx = (entry_idx < IDLE_LAST) ? entry_idx + 5'd1 : 5'd0;
               end
               st.pidx    = entry_idx;
               st.scroll  = 1'b1;
               disp_state = wslc_pkg::DSP_SCROLL;
               wait_ticks = '0;
            end else if (wait_ticks != '1) begin
               wait_ticks++;
            end
         end else begin
            disp_state = wslc_pkg::DSP_WAIT;
            if (wait_ticks != '1) wait_ticks++;
         end
      end
      return st;
   endfunction

   function automatic stim_row_type tick_row(input logic level);
      stim_row_type row;
      row = '{default: '0};
      row.level = level;
      return row;
   endfunction

   function automatic stim_row_type checked_row(input logic level,
                                                input tick_status_type want);
      stim_row_type row;
      row = tick_row(level);
      row.typed = 1'b1;
      row.want  = want;
      return row;
   endfunction

   function automatic stim_row_type write_row(
      input logic [wslc_pkg::CsrIdxWidth-1:0]  idx,
      input logic [wslc_pkg::CsrDataWidth-1:0] value);
      stim_row_type row;
      row = '{default: '0};
      row.is_write  = 1'b1;
      row.reg_idx   = idx;
      row.reg_value = value;
      return row;
   endfunction

   // Threshold pick: mostly low values that a slow wheel reaches, sometimes an extreme.
   function automatic logic [7:0] pick_level(input int top);
      int roll;
      roll = $urandom_range(9);
      if (roll == 0) return 8'd0;
      if (roll == 1) return 8'hFF;
      return 8'($urandom_range(top));
   endfunction

   // Sends one tick beat, idling at random, and books its expected status.
   task automatic send_tick(input logic level, input bit typed = 1'b0,
                            input tick_status_type want = '0);
      tick_status_type predicted;
      while (!steady_flow && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= 8'(level);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      predicted = advance_controller(level);
      pending_status.push_back(typed ? want : predicted);
      ticks_sent++;
   endtask

   // Register write at the next rising edge; the enable stays up for back-to-back writes.
   task automatic write_reg(input logic [wslc_pkg::CsrIdxWidth-1:0]  idx,
                            input logic [wslc_pkg::CsrDataWidth-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         wslc_pkg::CSR_WINDOW_LENGTH:    cfg_window = value[9:0];
         wslc_pkg::CSR_HOLD_TICKS:       cfg_hold   = value[11:0];
         wslc_pkg::CSR_ON_THRESHOLD:     cfg_on     = value[7:0];
         wslc_pkg::CSR_RESUME_THRESHOLD: cfg_resume = value[7:0];
         wslc_pkg::CSR_FAST_THRESHOLD:   cfg_fast   = value[7:0];
         wslc_pkg::CSR_MEDIUM_THRESHOLD: cfg_medium = value[7:0];
         wslc_pkg::CSR_DELAY_BASE:       cfg_delay  = value[7:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Stops sending and waits until every booked status beat has come back.
   task automatic wait_for_quiet();
      req_tvalid <= 1'b0;
      while (pending_status.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   // Status beat checker.
   always @(posedge clock) begin
      tick_status_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[19:0];
         if (got.strobe) latch_beats++;
         if (got.scroll) scroll_beats++;
         if (got.idle) hold_beats++;
         if (got.clear) dark_beats++;
         if (pending_status.size() == 0) begin
            $error("status beat arrived with no tick pending");
            mismatches++;
         end else begin
            want = pending_status.pop_front();
            check_field("system_on", want.on, got.on);
            check_field("holding_off", want.idle, got.idle);
            check_field("window_strobe", want.strobe, got.strobe);
            check_field("rate_count", want.rate, got.rate);
            check_field("scroll_strobe", want.scroll, got.scroll);
            check_field("pattern_set", want.pset, got.pset);
            check_field("pattern_index", want.pidx, got.pidx);
            check_field("clear_strip", want.clear, got.clear);
         end
      end
   end

   initial begin
      int          phase, span, sent, roll, seg_len, period, high_len, k;
      logic        lvl;
      logic [9:0]  win;
      bit          dirty, writing;

      // Model state after reset.
      cfg_window = wslc_pkg::WINDOW_LENGTH_RESET;
      cfg_hold   = wslc_pkg::HOLD_TICKS_RESET;
      cfg_on     = wslc_pkg::ON_THRESHOLD_RESET;
      cfg_resume = wslc_pkg::RESUME_THRESHOLD_RESET;
      cfg_fast   = wslc_pkg::FAST_THRESHOLD_RESET;
      cfg_medium = wslc_pkg::MEDIUM_THRESHOLD_RESET;
      cfg_delay  = wslc_pkg::DELAY_BASE_RESET;
      edge_state  = wslc_pkg::EDGE_IDLE;
      power_state = wslc_pkg::PWR_OFF;
      disp_state  = wslc_pkg::DSP_WAIT;
      pulse_tally = '0;  rate_latched = '0;  window_ticks = '0;
      hold_ticks_run = '0;  wait_ticks = '0;  entry_idx = '0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table. After reset the lights stay dark; then a window length of one
      // with zero thresholds powers up at once and scrolls without delay; a top
      // on-threshold forces hold-off, which lasts one tick past the hold length;
      // last, a masked all-ones delay base shows the delay floor from the far side.
      directed_rows = {
         checked_row(1'b1, DARK_AT_RESET),
         checked_row(1'b1, DARK_AT_RESET),
         checked_row(1'b0, DARK_AT_RESET),
         write_row(wslc_pkg::CSR_WINDOW_LENGTH, 12'd1),
         write_row(wslc_pkg::CSR_ON_THRESHOLD, 12'd0),
         write_row(wslc_pkg::CSR_DELAY_BASE, 12'd0),
         write_row(wslc_pkg::CSR_FAST_THRESHOLD, 12'd0),
         write_row(wslc_pkg::CSR_MEDIUM_THRESHOLD, 12'd0),
         write_row(wslc_pkg::CSR_HOLD_TICKS, 12'd1),
         write_row(wslc_pkg::CSR_RESUME_THRESHOLD, 12'd255),
         tick_row(1'b1), tick_row(1'b0), tick_row(1'b0),
         tick_row(1'b1), tick_row(1'b0), tick_row(1'b0),
         write_row(wslc_pkg::CSR_ON_THRESHOLD, 12'd255),
         write_row(CSR_SPARE_INDEX, 12'hFFF),
         tick_row(1'b0), tick_row(1'b0), tick_row(1'b0), tick_row(1'b0),
         write_row(wslc_pkg::CSR_WINDOW_LENGTH, 12'd4),
         write_row(wslc_pkg::CSR_ON_THRESHOLD, 12'd1),
         write_row(wslc_pkg::CSR_RESUME_THRESHOLD, 12'd1),
         write_row(wslc_pkg::CSR_HOLD_TICKS, 12'hFFF),
         write_row(wslc_pkg::CSR_FAST_THRESHOLD, 12'd255),
         write_row(wslc_pkg::CSR_MEDIUM_THRESHOLD, 12'd1),
         write_row(wslc_pkg::CSR_DELAY_BASE, 12'hFFF),
         tick_row(1'b1), tick_row(1'b0), tick_row(1'b0), tick_row(1'b1),
         tick_row(1'b0), tick_row(1'b0), tick_row(1'b1), tick_row(1'b0),
         tick_row(1'b0), tick_row(1'b0)
      };

      dirty = 1'b0;
      writing = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            if (dirty) begin
               wait_for_quiet();
               dirty = 1'b0;
            end
            write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_value);
            writing = 1'b1;
         end else begin
            if (writing) begin
               csr_we <= 1'b0;
               writing = 1'b0;
            end
            send_tick(directed_rows[i].level, directed_rows[i].typed, directed_rows[i].want);
            dirty = 1'b1;
         end
      end

      // Random phases: new settings, then sensor segments or, in phase 2, a pulse train.
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_TICKS) begin
         wait_for_quiet();
         steady_flow = (phase % 4 == 1) || (phase == 2);

         // Phase 2 uses a long window fed at the top pulse rate, so the latched
         // rate climbs well past the speed thresholds.
         roll = $urandom_range(9);
         if (phase == 2) win = 10'($urandom_range(100, 200));
         else if (roll == 0) win = 10'd1;
         else if (roll == 1) win = 10'h3FF;
         else win = 10'($urandom_range(1, 20));
         write_reg(wslc_pkg::CSR_WINDOW_LENGTH, {2'($urandom), win});

         roll = $urandom_range(9);
         if (roll == 0) write_reg(wslc_pkg::CSR_HOLD_TICKS, 12'hFFF);
         else if (roll == 1) write_reg(wslc_pkg::CSR_HOLD_TICKS, 12'd1);
         else write_reg(wslc_pkg::CSR_HOLD_TICKS, 12'($urandom_range(1, 40)));

         // Upper data bits above a register's width must be dropped.
         write_reg(wslc_pkg::CSR_ON_THRESHOLD, {4'($urandom), pick_level(6)});
         write_reg(wslc_pkg::CSR_RESUME_THRESHOLD, {4'($urandom), pick_level(8)});
         write_reg(wslc_pkg::CSR_FAST_THRESHOLD, {4'($urandom), pick_level(10)});
         write_reg(wslc_pkg::CSR_MEDIUM_THRESHOLD, {4'($urandom), pick_level(6)});
         write_reg(wslc_pkg::CSR_DELAY_BASE, {4'($urandom), pick_level(12)});
         write_reg(CSR_SPARE_INDEX, 12'($urandom));
         csr_we <= 1'b0;

         if (phase == 2) begin
            for (k = 0; k < int'(win) + 8; k++) send_tick(k % 3 == 0);
            sent += int'(win) + 8;
         end else begin
            span = $urandom_range(40, 120);
            k = 0;
            while (k < span) begin
               // Segment kinds: pulse train, quiet wheel, magnet parked, noise.
               roll     = $urandom_range(99);
               seg_len  = $urandom_range(6, 40);
               period   = $urandom_range(3, 6);
               high_len = $urandom_range(1, period - 1);
               for (int j = 0; j < seg_len && k < span; j++) begin
                  if (roll < 45) lvl = (j % period) < high_len;
                  else if (roll < 65) lvl = 1'b0;
                  else if (roll < 75) lvl = 1'b1;
                  else lvl = 1'($urandom_range(1));
                  send_tick(lvl);
                  k++;
               end
            end
            sent += span;
         end
         phase++;
      end

      wait_for_quiet();
      repeat (8) @(negedge clock);
      $display("Sent %0d sensor ticks across %0d random register settings, one of them",
               ticks_sent, phase);
      $display("a dense pulse train; saw %0d latches, %0d scrolls, %0d hold-off, %0d dark.",
               latch_beats, scroll_beats, hold_beats, dark_beats);
      if (mismatches == 0 && pending_status.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
